@@ hw/rtl/crspl_pkg.sv @@
// Shared types and fixed constants of the Catmull-Rom spline evaluator.
package crspl_pkg;

  // Fixed field widths.
  localparam int KC_W       = 6;   // knot count register
  localparam int IDX_W      = 5;   // knot index field
  localparam int VAL_W      = 32;  // knot and curve values
  localparam int POS_W      = 17;  // 1.16 position
  localparam int SEG_OUT_W  = 5;   // reported segment
  localparam int FRAC_BITS  = 16;  // fraction bits of the position

  // Curve geometry: two guard knots plus one for the segment count.
  localparam int MIN_KNOTS   = 4;
  localparam int GUARD_KNOTS = 3;

  // Request kinds.
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EVAL = 1'b1
  } action_t;

  // One input request.
  typedef struct packed {
    action_t                   action;
    logic [IDX_W-1:0]          knot_index;
    logic signed [VAL_W-1:0]   knot_value;
    logic [POS_W-1:0]          position;
  } in_t;

  // One result.
  typedef struct packed {
    logic signed [VAL_W-1:0]   curve_value;
    logic [SEG_OUT_W-1:0]      segment;
  } out_t;

  // Knot write toward the knot store.
  typedef struct packed {
    logic                      en;
    logic [IDX_W-1:0]          index;
    logic signed [VAL_W-1:0]   value;
  } knot_wr_t;

endpackage

@@ hw/rtl/catmull_rom_spline_eval_top.sv @@
// Top level of the Catmull-Rom spline evaluator.
//
// The block takes one request in every clock cycle: busy stays low, so a request
// is accepted whenever start is high. A load request writes one knot into the
// knot store at its accept edge and gives no result; an evaluate request gives
// one result on out_res, marked by out_strobe. On its way it passes one span
// stage, one knot store read and nine stages of the cubic datapath, whose
// second and third products are each cut into two narrower multipliers with
// a recombining stage after them. The receiver cannot stall, so results must
// be taken when shown. An evaluate request sees every load accepted before
// it. Knots are not cleared by reset; evaluate only over knots that have been
// loaded. Write the knot count only while no evaluate result is still
// pending.
module catmull_rom_spline_eval_top #(
  parameter int MAX_KNOTS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  crspl_pkg::in_t               in_req,
  output logic                         out_strobe,
  output crspl_pkg::out_t              out_res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [crspl_pkg::KC_W-1:0]   cfg_data
);
  import crspl_pkg::*;

  localparam int KC_MAX   = (1 << KC_W) - 1;
  localparam int KNOT_LIM = (MAX_KNOTS < KC_MAX) ? MAX_KNOTS : KC_MAX;
  localparam int SEG_W    = $clog2(KNOT_LIM - GUARD_KNOTS + 1);
  localparam int SC_W     = POS_W + SEG_W;
  localparam int SPAN_W   = SC_W - FRAC_BITS;
  localparam int LAT      = 11;

  logic              accept;
  logic [KC_W-1:0]   knot_count_r;
  knot_wr_t          wr;
  logic              v1;
  logic [SPAN_W-1:0] span1;
  logic [SC_W-1:0]   frac1;
  logic [3:0][VAL_W-1:0] knots;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Knot count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= KC_W'(MIN_KNOTS);
    end else if (cfg_valid && cfg_ready) begin
      knot_count_r <= cfg_data;
    end
  end

  crspl_front #(
    .KNOT_LIM (KNOT_LIM),
    .SEG_W    (SEG_W),
    .SC_W     (SC_W),
    .SPAN_W   (SPAN_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_req     (in_req),
    .knot_count (knot_count_r),
    .wr         (wr),
    .v1_r       (v1),
    .span1_r    (span1),
    .frac1_r    (frac1)
  );

  crspl_knot_mem #(
    .MAX_KNOTS (MAX_KNOTS),
    .SPAN_W    (SPAN_W)
  ) u_mem (
    .clk        (clk),
    .wr         (wr),
    .rd_en      (v1),
    .rd_span    (span1),
    .rd_knots_r (knots)
  );

  crspl_cubic #(
    .X_W (SC_W)
  ) u_cubic (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v1),
    .in_frac    (frac1),
    .in_seg     (SEG_OUT_W'(span1)),
    .knots      (knots),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  // Every evaluate request gives its result on out_strobe.
  a_eval_result : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.action == ACT_EVAL) |-> ##LAT out_strobe)
    else $error("evaluate request lost its result");

  // A result only ever follows an evaluate request.
  a_no_stray : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && in_req.action == ACT_EVAL, LAT))
    else $error("result without an evaluate request");

  // The reported segment never passes the last segment.
  a_seg_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((KNOT_LIM - MIN_KNOTS > 31) ||
                    (int'(out_res.segment) <= KNOT_LIM - MIN_KNOTS)))
    else $error("segment beyond the last segment");

endmodule

@@ hw/rtl/crspl_front.sv @@
// Request decode, knot count clamp and span/fraction stage.
module crspl_front #(
  parameter int KNOT_LIM = 32,
  parameter int SEG_W    = 5,
  parameter int SC_W     = 22,
  parameter int SPAN_W   = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  crspl_pkg::in_t           in_req,
  input  logic [crspl_pkg::KC_W-1:0] knot_count,
  output crspl_pkg::knot_wr_t      wr,
  output logic                     v1_r,
  output logic [SPAN_W-1:0]        span1_r,
  output logic [SC_W-1:0]          frac1_r
);
  import crspl_pkg::*;

  logic [KC_W-1:0]   n_knots;
  logic [SEG_W-1:0]  segs;
  logic [SC_W-1:0]   scaled;
  logic [SPAN_W-1:0] span_raw;
  logic [SPAN_W-1:0] span_nxt;
  logic [SC_W-1:0]   frac_nxt;
  logic              v1_nxt;

  // Load requests go straight to the knot store at the accept edge.
  always_comb begin
    wr.en    = accept && (in_req.action == ACT_LOAD);
    wr.index = in_req.knot_index;
    wr.value = in_req.knot_value;
  end

  // Clamp the knot count into the supported range.
  always_comb begin
    if (knot_count < KC_W'(MIN_KNOTS)) begin
      n_knots = KC_W'(MIN_KNOTS);
    end else if (knot_count > KC_W'(KNOT_LIM)) begin
      n_knots = KC_W'(KNOT_LIM);
    end else begin
      n_knots = knot_count;
    end
  end

  // Scale the position by the segment count and split it into span and fraction.
  always_comb begin
    segs     = SEG_W'(n_knots - KC_W'(GUARD_KNOTS));
    scaled   = SC_W'(in_req.position) * SC_W'(segs);
    span_raw = scaled[SC_W-1:FRAC_BITS];
    if (span_raw >= SPAN_W'(segs)) begin
      span_nxt = SPAN_W'(n_knots - KC_W'(MIN_KNOTS));
    end else begin
      span_nxt = span_raw;
    end
    frac_nxt = scaled - {span_nxt, {FRAC_BITS{1'b0}}};
    v1_nxt   = accept && (in_req.action == ACT_EVAL);
  end

  // Stage one registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span1_r <= span_nxt;
    frac1_r <= frac_nxt;
  end

endmodule

@@ hw/rtl/crspl_knot_mem.sv @@
// Knot store: two replicated copies, each read at two addresses per cycle.
module crspl_knot_mem #(
  parameter int MAX_KNOTS = 32,
  parameter int SPAN_W    = 6
) (
  input  logic                                   clk,
  input  crspl_pkg::knot_wr_t                    wr,
  input  logic                                   rd_en,
  input  logic [SPAN_W-1:0]                      rd_span,
  output logic [3:0][crspl_pkg::VAL_W-1:0]       rd_knots_r
);
  import crspl_pkg::*;

  localparam int ADDR_W = $clog2(MAX_KNOTS);
  localparam int SUM_W  = ((SPAN_W > ADDR_W) ? SPAN_W : ADDR_W) + 1;

  // Copy A serves knots span and span+1, copy B serves span+2 and span+3.
  logic [VAL_W-1:0]  knot_a_r [MAX_KNOTS];
  logic [VAL_W-1:0]  knot_b_r [MAX_KNOTS];
  logic [ADDR_W-1:0] rd_addr [4];
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_ok;
  logic [SUM_W-1:0]  sum;

  // Read addresses of the four consecutive knots; a clamped span keeps them in range.
  always_comb begin
    sum = '0;
    for (int j = 0; j < 4; j++) begin
      sum        = SUM_W'(rd_span) + SUM_W'(j);
      rd_addr[j] = sum[ADDR_W-1:0];
    end
    wr_addr = ADDR_W'(wr.index);
    wr_ok   = wr.en && (int'(wr.index) < MAX_KNOTS);
  end

  // Both copies take every write. A write lands at its accept edge and the
  // evaluate read is taken from the span stage register, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      knot_a_r[wr_addr] <= wr.value;
      knot_b_r[wr_addr] <= wr.value;
    end
  end

  // Registered reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_knots_r[0] <= knot_a_r[rd_addr[0]];
      rd_knots_r[1] <= knot_a_r[rd_addr[1]];
      rd_knots_r[2] <= knot_b_r[rd_addr[2]];
      rd_knots_r[3] <= knot_b_r[rd_addr[3]];
    end
  end

endmodule

@@ hw/rtl/crspl_cubic.sv @@
// Coefficient and Horner cubic pipeline with split multipliers.
module crspl_cubic #(
  parameter int X_W = 22
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [X_W-1:0]                     in_frac,
  input  logic [crspl_pkg::SEG_OUT_W-1:0]    in_seg,
  input  logic [3:0][crspl_pkg::VAL_W-1:0]   knots,
  output logic                               out_strobe,
  output crspl_pkg::out_t                    out_res
);
  import crspl_pkg::*;

  localparam int P1_W   = X_W + 1 + VAL_W;
  localparam int S2_W   = P1_W - FRAC_BITS + 1;
  localparam int LO2_W  = 20;
  localparam int HI2_W  = S2_W - LO2_W;
  localparam int P2_W   = X_W + 1 + S2_W;
  localparam int ACC_W  = 48;
  localparam int HALF_W = ACC_W / 2;

  function automatic logic signed [VAL_W-1:0] half(input logic signed [VAL_W-1:0] v);
    return v >>> 1;
  endfunction

  // Carried fields; the index is the stage number.
  logic [11:2]                 v_r;
  logic [X_W-1:0]              x_r   [2:8];
  logic [SEG_OUT_W-1:0]        seg_r [2:10];
  logic signed [VAL_W-1:0]     k1_r  [3:10];
  logic signed [VAL_W:0]       hk_r  [3:7];
  logic signed [VAL_W-1:0]     c2_r  [3:4];
  logic signed [VAL_W-1:0]     c1_r;

  // Datapath registers.
  logic signed [P1_W-1:0]            p1_r,   p1_nxt;
  logic signed [S2_W-1:0]            s2_r,   s2_nxt;
  logic [X_W+LO2_W-1:0]              m2lo_r, m2lo_nxt;
  logic signed [X_W+HI2_W:0]         m2hi_r, m2hi_nxt;
  logic signed [P2_W-1:0]            p2_r,   p2_nxt;
  logic signed [ACC_W-1:0]           acc_r,  acc_nxt;
  logic [X_W+HALF_W-1:0]             m3lo_r, m3lo_nxt;
  logic [HALF_W-1:0]                 m3hi_r, m3hi_nxt;
  logic [ACC_W-1:0]                  p3_r,   p3_nxt;
  logic signed [VAL_W-1:0]           c1_nxt, c2_nxt;
  logic signed [VAL_W:0]             hk_nxt;
  out_t                              out_res_r, out_res_nxt;

  // Stage three: cubic coefficients; the first two wrap at 32 bits, the linear term keeps 33.
  always_comb begin
    logic signed [VAL_W-1:0] k0, k1, k2, k3;
    k0 = knots[0];
    k1 = knots[1];
    k2 = knots[2];
    k3 = knots[3];
    c1_nxt = half(k1) - half(k2) - k2 + k1 + half(k3) + half(~k0);
    c2_nxt = (k2 <<< 1) - (k1 <<< 1) - half(k1) - half(k3) + k0;
    hk_nxt = (VAL_W + 1)'(half(k2)) + (VAL_W + 1)'(half(~k0));
  end

  // Stage four: first Horner product.
  always_comb begin
    p1_nxt = $signed({1'b0, x_r[3]}) * c1_r;
  end

  // Stage five: scale and add the second coefficient.
  always_comb begin
    logic signed [S2_W-1:0] a, b;
    a      = S2_W'(p1_r >>> FRAC_BITS);
    b      = S2_W'(c2_r[4]);
    s2_nxt = a + b;
  end

  // Stage six: second product in two halves.
  always_comb begin
    m2lo_nxt = x_r[5] * s2_r[LO2_W-1:0];
    m2hi_nxt = $signed({1'b0, x_r[5]}) * $signed(s2_r[S2_W-1:LO2_W]);
  end

  // Stage seven: recombine the halves.
  always_comb begin
    logic signed [P2_W-1:0] hi_ext, lo_ext;
    hi_ext = P2_W'(m2hi_r);
    lo_ext = P2_W'(m2lo_r);
    p2_nxt = (hi_ext <<< LO2_W) + lo_ext;
  end

  // Stage eight: scale and add the linear term. Only the low 48 bits feed
  // the bits of the last product that survive.
  always_comb begin
    logic signed [ACC_W-1:0] a, b;
    a       = ACC_W'(p2_r >>> FRAC_BITS);
    b       = ACC_W'(hk_r[7]);
    acc_nxt = a + b;
  end

  // Stage nine: last product modulo 2^48, in two halves.
  always_comb begin
    logic [X_W+HALF_W-1:0] hi_full;
    m3lo_nxt = x_r[8] * acc_r[HALF_W-1:0];
    hi_full  = x_r[8] * acc_r[ACC_W-1:HALF_W];
    m3hi_nxt = hi_full[HALF_W-1:0];
  end

  // Stage ten: recombine the last product.
  always_comb begin
    p3_nxt = ACC_W'(m3lo_r) + {m3hi_r, {HALF_W{1'b0}}};
  end

  // Stage eleven: scale, add the start knot and truncate.
  always_comb begin
    out_res_nxt.curve_value = p3_r[FRAC_BITS+VAL_W-1:FRAC_BITS] + k1_r[10];
    out_res_nxt.segment     = seg_r[10];
  end

  // Valid line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[10:2], in_valid};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    x_r[2]   <= in_frac;
    seg_r[2] <= in_seg;
    for (int i = 3; i <= 8; i++) begin
      x_r[i] <= x_r[i-1];
    end
    for (int i = 3; i <= 10; i++) begin
      seg_r[i] <= seg_r[i-1];
    end
    k1_r[3] <= knots[1];
    for (int i = 4; i <= 10; i++) begin
      k1_r[i] <= k1_r[i-1];
    end
    hk_r[3] <= hk_nxt;
    for (int i = 4; i <= 7; i++) begin
      hk_r[i] <= hk_r[i-1];
    end
    c1_r      <= c1_nxt;
    c2_r[3]   <= c2_nxt;
    c2_r[4]   <= c2_r[3];
    p1_r      <= p1_nxt;
    s2_r      <= s2_nxt;
    m2lo_r    <= m2lo_nxt;
    m2hi_r    <= m2hi_nxt;
    p2_r      <= p2_nxt;
    acc_r     <= acc_nxt;
    m3lo_r    <= m3lo_nxt;
    m3hi_r    <= m3hi_nxt;
    p3_r      <= p3_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = v_r[11];
  assign out_res    = out_res_r;

endmodule
